[hw/rtl/sdhf_pkg.sv]
// sdhf_pkg: shared constants and types of the sparse depth hole fill block
// used by sdhf_div and sparse_depth_hole_fill_3x3; depends on nothing
`default_nettype none

package sdhf_pkg;

   // frame geometry
   localparam int IMAGE_WIDTH  = 1920;
   localparam int IMAGE_HEIGHT = 1080;

   // field widths
   localparam int DEPTH_W = 16;
   localparam int COORD_W = 11;
   localparam int ADDR_W  = $clog2(IMAGE_WIDTH);

   // window and mean arithmetic
   localparam int WIN_N   = 9;
   localparam int WCOL_N  = 6;
   localparam int STEP_W  = $clog2(WIN_N);
   localparam int SUM_W   = $clog2(WIN_N * (2 ** DEPTH_W - 1) + 1);
   localparam int CNT_W   = $clog2(WIN_N + 1);
   localparam int DSTEP_W = $clog2(SUM_W + 1);

   // line store word: upper row in the high half, middle row in the low half
   localparam int LINE_W = 2 * DEPTH_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SUM,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic               start;
      logic [SUM_W-1:0]   dividend;
      logic [CNT_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DEPTH_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] filled_depth;
      logic [COORD_W-1:0] pixel_col;
      logic [COORD_W-1:0] pixel_row;
      logic               frame_done;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/sdhf_ram.sv]
// sdhf_ram: generic single-clock RAM, one write port, one read port
// read data registered; no dependencies
`default_nettype none

module sdhf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1920
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/sdhf_div.sv]
// sdhf_div: radix-2 restoring divider, window sum by nonzero count
// one quotient bit per cycle; depends on sdhf_pkg
`default_nettype none

module sdhf_div
   import sdhf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic               busy_ff;
   logic               done_ff;
   logic [DSTEP_W-1:0] step_ff;
   logic [CNT_W-1:0]   rem_ff;
   logic [SUM_W-1:0]   quo_ff;
   logic [CNT_W-1:0]   divisor_ff;

   logic [CNT_W:0]     trial;
   logic [CNT_W:0]     diff;
   logic               ge;
   logic [CNT_W-1:0]   rem_in;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_W-1]};
      ge     = (trial >= {1'b0, divisor_ff});
      diff   = trial - {1'b0, divisor_ff};
      rem_in = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == DSTEP_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff     <= '0;
         quo_ff     <= div_req.dividend;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[SUM_W-2:0], ge};
      end
   end

   // the mean of 16-bit values never exceeds 16 bits
   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[DEPTH_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/sparse_depth_hole_fill_3x3.sv]
// sparse_depth_hole_fill_3x3: 3x3 masked mean over a raster depth stream
// depends on sdhf_pkg, sdhf_ram (line stores) and sdhf_div (mean divider)
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    depth_sample, frame_start
//   rsp      out  rsp_valid/rsp_ready    filled_depth, pixel_col, pixel_row, frame_done
//
// An interior request runs from its accepting cycle through the line store read,
// nine accumulate steps, the serial divider and the emit state.
// A border request skips the accumulate and divide steps, a request with no result
// returns to idle after the read, and an empty window skips the divider.
// Reset is synchronous; the line stores are not cleared and need no pass.
// Results wait in a two-entry queue; a request is taken while results wait there.
`default_nettype none

module sparse_depth_hole_fill_3x3
   import sdhf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [DEPTH_W-1:0] req_depth_sample,
   input  wire logic               req_frame_start,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [DEPTH_W-1:0] rsp_filled_depth,
   output logic      [COORD_W-1:0] rsp_pixel_col,
   output logic      [COORD_W-1:0] rsp_pixel_row,
   output logic                    rsp_frame_done
);

   state_type          state_ff, state_in;

   logic [COORD_W-1:0] col_ff, row_ff;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [DEPTH_W-1:0] sample_ff;
   logic [DEPTH_W-1:0] win_ff [WIN_N];
   logic [DEPTH_W-1:0] wc_ff  [WCOL_N];
   logic [STEP_W-1:0]  step_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DEPTH_W-1:0] val_ff;

   result_type         q_ff [2];
   result_type         q_in [2];
   logic [1:0]         qcnt_ff, qcnt_in;

   logic               accept;
   logic [COORD_W-1:0] x_acc, y_acc;
   logic [LINE_W-1:0]  line_rd;
   logic [DEPTH_W-1:0] line_up, line_mid;
   logic               has_res, interior, two_res, room;
   logic [SUM_W-1:0]   sum_add;
   logic [CNT_W-1:0]   cnt_add;
   logic               sum_last;
   logic               line_wr;
   logic               push, pop;
   logic [1:0]         qcnt_post;
   result_type         res0, res1;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // position of the accepted pixel
   assign accept = req_valid && req_ready;
   assign x_acc  = req_frame_start ? '0 : col_ff;
   assign y_acc  = req_frame_start ? '0 : row_ff;

   // line stores: upper and middle rows share one word per column
   sdhf_ram #(
      .WIDTH (LINE_W),
      .DEPTH (IMAGE_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (x_ff[ADDR_W-1:0]),
      .wr_data ({line_mid, sample_ff}),
      .rd_addr (x_acc[ADDR_W-1:0]),
      .rd_data (line_rd)
   );

   assign line_up  = line_rd[LINE_W-1:DEPTH_W];
   assign line_mid = line_rd[DEPTH_W-1:0];

   // mean divider
   sdhf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // classification of the current pixel
   assign has_res  = (x_ff != '0) && (y_ff != '0);
   assign interior = (x_ff >= COORD_W'(2)) && (y_ff >= COORD_W'(2));
   assign two_res  = (x_ff == COORD_W'(IMAGE_WIDTH - 1));
   assign room     = two_res ? (qcnt_ff == 2'd0) : (qcnt_ff != 2'd2);

   // accumulate one window value per step
   assign sum_add  = sum_ff + SUM_W'(win_ff[0]);
   assign cnt_add  = cnt_ff + CNT_W'(win_ff[0] != '0);
   assign sum_last = (step_ff == STEP_W'(WIN_N - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_READ;
         end
         ST_READ: begin
            priority if (!has_res) state_in = ST_IDLE;
            else if (interior)     state_in = ST_SUM;
            else                   state_in = ST_EMIT;
         end
         ST_SUM: begin
            if (sum_last) state_in = (cnt_add != '0) ? ST_DIV : ST_EMIT;
         end
         ST_DIV: begin
            if (div_rsp.done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (room) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready        = 1'b0;
      line_wr          = 1'b0;
      push             = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = sum_add;
      div_req.divisor  = cnt_add;
      unique case (state_ff)
         ST_IDLE: req_ready     = 1'b1;
         ST_READ: line_wr       = 1'b1;
         ST_SUM:  div_req.start = sum_last && (cnt_add != '0);
         ST_DIV:  ;
         ST_EMIT: push          = room;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (x_acc == COORD_W'(IMAGE_WIDTH - 1)) begin
            col_ff <= '0;
            row_ff <= (y_acc == COORD_W'(IMAGE_HEIGHT - 1)) ? '0 : y_acc + 1'b1;
         end else begin
            col_ff <= x_acc + 1'b1;
            row_ff <= y_acc;
         end
      end
   end

   // column window, columns x-2 and x-1 as top, middle, bottom
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WCOL_N; i++) wc_ff[i] <= '0;
      end else if (state_ff == ST_READ) begin
         wc_ff[0] <= wc_ff[3];
         wc_ff[1] <= wc_ff[4];
         wc_ff[2] <= wc_ff[5];
         wc_ff[3] <= line_up;
         wc_ff[4] <= line_mid;
         wc_ff[5] <= sample_ff;
      end
   end

   // request capture, window load, accumulation and mean
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_depth_sample;
         x_ff      <= x_acc;
         y_ff      <= y_acc;
      end
      unique case (state_ff)
         ST_READ: begin
            win_ff[0] <= wc_ff[0];
            win_ff[1] <= wc_ff[3];
            win_ff[2] <= line_up;
            win_ff[3] <= wc_ff[1];
            win_ff[4] <= wc_ff[4];
            win_ff[5] <= line_mid;
            win_ff[6] <= wc_ff[2];
            win_ff[7] <= wc_ff[5];
            win_ff[8] <= sample_ff;
            sum_ff    <= '0;
            cnt_ff    <= '0;
            step_ff   <= '0;
            val_ff    <= '0;
         end
         ST_SUM: begin
            for (int i = 0; i < WIN_N - 1; i++) win_ff[i] <= win_ff[i+1];
            sum_ff  <= sum_add;
            cnt_ff  <= cnt_add;
            step_ff <= step_ff + 1'b1;
         end
         ST_DIV: begin
            if (div_rsp.done) val_ff <= div_rsp.quotient;
         end
         ST_IDLE, ST_EMIT: ;
         default: ;
      endcase
   end

   // results of the current pixel: the centre, then the right border pixel
   always_comb begin
      res0.filled_depth = val_ff;
      res0.pixel_col    = x_ff - 1'b1;
      res0.pixel_row    = y_ff - 1'b1;
      res0.frame_done   = 1'b0;
      res1.filled_depth = '0;
      res1.pixel_col    = x_ff;
      res1.pixel_row    = y_ff - 1'b1;
      res1.frame_done   = (y_ff == COORD_W'(IMAGE_HEIGHT - 1));
   end

   // two-entry result queue, head at entry 0
   assign pop = rsp_valid && rsp_ready;

   always_comb begin
      q_in[0]   = q_ff[0];
      q_in[1]   = q_ff[1];
      qcnt_post = qcnt_ff - 2'(pop);
      if (pop) q_in[0] = q_ff[1];
      if (push) begin
         q_in[qcnt_post[0]] = res0;
         if (two_res) q_in[1] = res1;
      end
      qcnt_in = qcnt_post + 2'(push) + 2'(push && two_res);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qcnt_ff <= '0;
      end else begin
         qcnt_ff <= qcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   assign rsp_valid        = (qcnt_ff != 2'd0);
   assign rsp_filled_depth = q_ff[0].filled_depth;
   assign rsp_pixel_col    = q_ff[0].pixel_col;
   assign rsp_pixel_row    = q_ff[0].pixel_row;
   assign rsp_frame_done   = q_ff[0].frame_done;

   // a pair of results only goes into an empty queue
   a_pair_room: assert property (@(posedge clock) disable iff (reset)
      (push && two_res) |-> (qcnt_ff == 2'd0))
      else $error("result pair pushed into a nonempty queue");

   // the queue never holds more than two results
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff != 2'd3)
      else $error("result queue overflow");

   // the divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // the divider is never restarted while busy
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // the frame end marker sits only on the last emitted pixel
   a_frame_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |->
         ((rsp_pixel_col == COORD_W'(IMAGE_WIDTH - 1)) &&
          (rsp_pixel_row == COORD_W'(IMAGE_HEIGHT - 2))))
      else $error("frame end marker on the wrong pixel");

endmodule

`default_nettype wire
